// ===== src/itaf_pkg.sv =====
// itaf_pkg: shared types, constants and glyph function of the integer to ascii formatter
`default_nettype none

package itaf_pkg;

    // input opcodes
    typedef enum logic [2:0] {
        OP_HEX8  = 3'd0,
        OP_HEX16 = 3'd1,
        OP_HEX32 = 3'd2,
        OP_DEC16 = 3'd3,
        OP_DEC32 = 3'd4
    } t_opcode;

    localparam int VALUE_W   = 32;
    localparam int NIB_W     = 4;
    localparam int DIGITS    = 10;                 // decimal digits of a 32-bit magnitude
    localparam int BCD_W     = DIGITS * NIB_W;
    localparam int POS_W     = 4;                  // indexes up to DIGITS-1
    localparam int CNT_W     = 6;                  // holds DEC32_STEPS

    localparam logic [CNT_W-1:0] DEC16_STEPS = 6'd16;
    localparam logic [CNT_W-1:0] DEC32_STEPS = 6'd32;

    localparam logic [POS_W-1:0] HEX8_TOP  = 4'd1;
    localparam logic [POS_W-1:0] HEX16_TOP = 4'd3;
    localparam logic [POS_W-1:0] HEX32_TOP = 4'd7;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h41;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;                // holds QUEUE_DEPTH

    typedef struct packed {
        logic [2:0]         opcode;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out_word;

    // classified job handed from front to back
    typedef struct packed {
        logic               is_dec;
        logic               neg;
        logic               dec16;
        logic [POS_W-1:0]   top;
        logic [VALUE_W-1:0] mag;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // '0'..'9', 'A'..'F'
    function automatic logic [7:0] hex_glyph(input logic [NIB_W-1:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_ALPHA + {4'd0, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/itaf_queue.sv =====
// itaf_queue: two-entry job queue between the front and back parts
`default_nettype none

module itaf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire itaf_pkg::t_job     i_push_job,
    input  wire logic               i_pop,
    output itaf_pkg::t_job          o_head_job,
    output itaf_pkg::t_q_status     o_status
);

    itaf_pkg::t_job                        r_mem [itaf_pkg::QUEUE_DEPTH];
    logic [itaf_pkg::QUEUE_AW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [itaf_pkg::QUEUE_AW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [itaf_pkg::QUEUE_CW-1:0]         r_count,  n_count;
    logic                                  do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == itaf_pkg::QUEUE_CW'(itaf_pkg::QUEUE_DEPTH));
    assign o_head_job     = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/itaf_front.sv =====
// itaf_front: input word acceptance and opcode classification into jobs
`default_nettype none

module itaf_front (
    input  wire logic                i_in_valid,
    input  wire itaf_pkg::t_in_word  i_in_word,
    output logic                     o_in_stall,
    input  wire itaf_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output itaf_pkg::t_job           o_job
);

    logic                               known_op;
    logic [itaf_pkg::VALUE_W-1:0]       dec_bits;
    logic [itaf_pkg::VALUE_W-1:0]       dec_neg_mag;

    assign o_in_stall = i_q_status.full;

    // dec16 only looks at the low half
    assign dec_bits = (i_in_word.opcode == itaf_pkg::OP_DEC16)
                      ? {16'd0, i_in_word.value[15:0]}
                      : i_in_word.value;

    // two's complement magnitude; the most negative value wraps to its own true magnitude
    assign dec_neg_mag = (~dec_bits) + 1'b1;

    always_comb begin
        known_op = 1'b1;
        o_job    = '0;
        case (i_in_word.opcode)
            itaf_pkg::OP_HEX8: begin
                o_job.top = itaf_pkg::HEX8_TOP;
                o_job.mag = {24'd0, i_in_word.value[7:0]};
            end
            itaf_pkg::OP_HEX16: begin
                o_job.top = itaf_pkg::HEX16_TOP;
                o_job.mag = {16'd0, i_in_word.value[15:0]};
            end
            itaf_pkg::OP_HEX32: begin
                o_job.top = itaf_pkg::HEX32_TOP;
                o_job.mag = i_in_word.value;
            end
            itaf_pkg::OP_DEC16: begin
                o_job.is_dec = 1'b1;
                o_job.dec16  = 1'b1;
                o_job.neg    = i_in_word.value[15];
                o_job.mag    = i_in_word.value[15] ? {16'd0, dec_neg_mag[15:0]} : dec_bits;
            end
            itaf_pkg::OP_DEC32: begin
                o_job.is_dec = 1'b1;
                o_job.neg    = i_in_word.value[31];
                o_job.mag    = i_in_word.value[31] ? dec_neg_mag : dec_bits;
            end
            default: begin
                known_op = 1'b0;
            end
        endcase
    end

    // unknown opcodes are accepted and dropped
    assign o_push = i_in_valid && !i_q_status.full && known_op;

endmodule

`default_nettype wire

// ===== src/itaf_back.sv =====
// itaf_back: binary to bcd conversion and one-character-per-word emitter
`default_nettype none

module itaf_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire itaf_pkg::t_q_status i_q_status,
    input  wire itaf_pkg::t_job      i_head_job,
    output logic                     o_pop,
    output logic                     o_out_valid,
    output itaf_pkg::t_out_word      o_out_word,
    input  wire logic                i_out_stall
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [itaf_pkg::BCD_W-1:0]         r_bcd,   n_bcd;
    logic [itaf_pkg::VALUE_W-1:0]       r_bin,   n_bin;
    logic [itaf_pkg::CNT_W-1:0]         r_cnt,   n_cnt;
    logic [itaf_pkg::POS_W-1:0]         r_pos,   n_pos;
    logic                               r_neg,   n_neg;
    logic                               r_out_valid, n_out_valid;
    itaf_pkg::t_out_word                r_out_word,  n_out_word;

    logic [itaf_pkg::BCD_W-1:0]         bcd_adj;
    logic [itaf_pkg::POS_W-1:0]         msd_pos;
    logic [itaf_pkg::NIB_W-1:0]         cur_nib;
    logic                               slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign cur_nib     = r_bcd[{r_pos, 2'b00} +: itaf_pkg::NIB_W];

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < itaf_pkg::DIGITS; i++) begin
            bcd_adj[i*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] =
                (r_bcd[i*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] >= 4'd5)
                ? r_bcd[i*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] + 4'd3
                : r_bcd[i*itaf_pkg::NIB_W +: itaf_pkg::NIB_W];
        end
    end

    // highest nonzero digit, zero if the value is zero
    always_comb begin
        msd_pos = '0;
        for (int i = 0; i < itaf_pkg::DIGITS; i++) begin
            if (r_bcd[i*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] != '0) begin
                msd_pos = itaf_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    n_neg = i_head_job.neg;
                    if (i_head_job.is_dec) begin
                        n_bcd   = '0;
                        n_bin   = i_head_job.dec16 ? {i_head_job.mag[15:0], 16'd0}
                                                   : i_head_job.mag;
                        n_cnt   = i_head_job.dec16 ? itaf_pkg::DEC16_STEPS
                                                   : itaf_pkg::DEC32_STEPS;
                        n_state = ST_CONV;
                    end else begin
                        n_bcd   = {8'd0, i_head_job.mag};
                        n_pos   = i_head_job.top;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[itaf_pkg::BCD_W-2:0], r_bin[itaf_pkg::VALUE_W-1]};
                n_bin = {r_bin[itaf_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == itaf_pkg::CNT_W'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_pos   = msd_pos;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_word.char_code = itaf_pkg::CH_MINUS;
                        n_out_word.last      = 1'b0;
                        n_neg                = 1'b0;
                    end else begin
                        n_out_word.char_code = itaf_pkg::hex_glyph(cur_nib);
                        n_out_word.last      = (r_pos == '0);
                        if (r_pos == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_pos = r_pos - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd      <= n_bcd;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_neg      <= n_neg;
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// integer_to_ascii_formatter: top level, integer value to ascii character stream
//
// input channel: i_in_valid / o_in_stall carry one word {opcode, value}
//   opcode hex8/hex16/hex32 gives 2/4/8 uppercase hex digits, msd first
//   opcode dec16/dec32 gives signed decimal: '-' if negative, then the
//   magnitude without leading zeros ("0" for zero); unknown opcodes are
//   taken and dropped with no output
// output channel: o_out_valid / i_out_stall carry one character per word,
//   with last set on the final character of each value
// hex jobs go from the back part's idle state straight to emission;
//   decimal jobs run the shift-add-3 conversion over the magnitude bits,
//   then a digit scan, before the first character
// throughput: one character per cycle while the receiver takes them; the
//   back part takes the next job only after the last character of the
//   current one, and the bcd conversion loop sets the decimal cost
// a two-word job queue lets input words be taken while the back part works
// reset (synchronous, active low) empties the queue and output register
// a stall on the output holds the current character; the back part waits
//   in its emit state and the input side stalls once the queue fills
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire itaf_pkg::t_in_word  i_in_word,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output itaf_pkg::t_out_word      o_out_word,
    input  wire logic                i_out_stall
);

    itaf_pkg::t_q_status  q_status;
    itaf_pkg::t_job       push_job;
    itaf_pkg::t_job       head_job;
    logic                 push;
    logic                 pop;

    // front: classify opcode, build magnitude and sign
    itaf_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decoupling queue between front and back
    itaf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head_job (head_job),
        .o_status   (q_status)
    );

    // back: bcd conversion and character emission
    itaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head_job  (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== src/itaf_checker.sv =====
// itaf_checker: port-level assertions for the formatter, bound to the top level
`default_nettype none

module itaf_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_out_valid,
    input  wire itaf_pkg::t_out_word o_out_word,
    input  wire logic                i_out_stall
);

    // output register is cleared by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // only digits, uppercase hex letters or minus
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_word.char_code >= 8'h30) && (o_out_word.char_code <= 8'h39)) ||
            ((o_out_word.char_code >= 8'h41) && (o_out_word.char_code <= 8'h46)) ||
            (o_out_word.char_code == itaf_pkg::CH_MINUS))
        else $error("illegal character code");

    // a minus sign is never marked last: digits follow it
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.char_code == itaf_pkg::CH_MINUS) |-> !o_out_word.last)
        else $error("minus sign marked last");

    // a taken minus is never followed directly by another minus
    a_no_double_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_out_word.char_code == itaf_pkg::CH_MINUS)
        |=> !(o_out_valid && (o_out_word.char_code == itaf_pkg::CH_MINUS)))
        else $error("two minus signs in a row");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of the integer to ascii formatter
module tb_top;
    import itaf_pkg::*;

    localparam int ITEM_TARGET    = 96;    // random values that produce text
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 100;   // beyond the slowest dec32 conversion

    // opcodes without meaning, dropped by the block
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // spells each accepted value the way the block must and matches the
    // character stream against it in order
    class text_scoreboard;
        t_out_word   expected_chars[$];
        string       hex_glyphs = "0123456789ABCDEF";
        int unsigned mismatches;
        int unsigned values_spelled;
        int unsigned ignored_words;
        int unsigned chars_checked;

        function new();
            mismatches     = 0;
            values_spelled = 0;
            ignored_words  = 0;
            chars_checked  = 0;
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void note_word(t_in_word w);
            logic [7:0]  text[$];
            logic [31:0] mag;
            int          ndig;
            bit          neg;
            t_out_word   ch;
            neg  = 1'b0;
            ndig = 0;
            mag  = '0;
            case (w.opcode)
                OP_HEX8:  ndig = 2;
                OP_HEX16: ndig = 4;
                OP_HEX32: ndig = 8;
                OP_DEC16: begin
                    // 17-bit subtract keeps -32768 at its true magnitude
                    neg = w.value[15];
                    mag = neg ? 32'(17'h1_0000 - {1'b0, w.value[15:0]})
                              : {16'd0, w.value[15:0]};
                end
                OP_DEC32: begin
                    // as unsigned, the negation of 0x80000000 is 2147483648
                    neg = w.value[31];
                    mag = neg ? (~w.value + 32'd1) : w.value;
                end
                default: begin
                    ignored_words++;
                    return;
                end
            endcase
            if (ndig > 0) begin
                for (int k = ndig - 1; k >= 0; k--) begin
                    text.push_back(hex_glyphs[w.value[4*k +: 4]]);
                end
            end else begin
                if (mag == 32'd0) begin
                    text.push_back(CH_ZERO);
                end
                while (mag != 32'd0) begin
                    text.push_front(CH_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end
                if (neg) begin
                    text.push_front(CH_MINUS);
                end
            end
            foreach (text[i]) begin
                ch.char_code = text[i];
                ch.last      = (i == text.size() - 1);
                expected_chars.push_back(ch);
            end
            values_spelled++;
        endfunction

        function void check_char(t_out_word got);
            t_out_word want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                flag($sformatf("char 0x%02h last=%0b arrived with nothing pending",
                               got.char_code, got.last));
                return;
            end
            want = expected_chars.pop_front();
            if (got.char_code !== want.char_code || got.last !== want.last) begin
                flag($sformatf("char #%0d expected 0x%02h last=%0b, got 0x%02h last=%0b",
                               chars_checked, want.char_code, want.last,
                               got.char_code, got.last));
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    text_scoreboard sb;

    // sender idling: stretches of calm (no gaps) alternate with random gaps
    int unsigned tx_left = 0;
    bit          tx_calm = 1'b0;
    int unsigned directed_count = 0;

    // watchdog bookkeeping
    logic        in_taken;
    logic        out_taken;
    int unsigned quiet_cycles = 0;

    integer_to_ascii_formatter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign in_taken  = in_valid && !in_stall;
    assign out_taken = out_valid && !out_stall;

    // every character the block hands over is checked at the edge it moves
    always @(posedge clk) begin
        if (rst_n && out_taken) begin
            sb.check_char(out_word);
        end
    end

    always @(posedge clk) begin
        quiet_cycles <= (!rst_n || in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end

    // a hang on either side ends the run here
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
        end
        $display("watchdog: no word moved for %0d cycles, %0d chars still pending",
                 WATCHDOG_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // character sink: before each word it may hold stall, except in calm
    // stretches where it takes everything at once
    initial begin : char_sink
        int unsigned hold;
        int unsigned left;
        bit          calm;
        left = 0;
        calm = 1'b0;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                left = $urandom_range(5, 24);
            end
            left--;
            hold = calm ? 0 : $urandom_range(0, 5);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic t_in_word pack_word(logic [2:0] op, logic [31:0] v);
        t_in_word w;
        w.opcode = op;
        w.value  = v;
        return w;
    endfunction

    // offer one word after a random gap and hold it until it is taken
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        if (tx_left == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tx_left = $urandom_range(4, 16);
        end
        tx_left--;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
    endtask

    // sender holds off until the block has handed over all pending text
    task automatic wait_for_text();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        t_in_word words[$];
        // hex: all-zero, all-one and every glyph, junk above the used width
        words.push_back(pack_word(OP_HEX8,  32'h0000_0000));
        words.push_back(pack_word(OP_HEX8,  32'hABCD_EFFF));
        words.push_back(pack_word(OP_HEX16, 32'h0000_0000));
        words.push_back(pack_word(OP_HEX16, 32'h1234_FFFF));
        words.push_back(pack_word(OP_HEX32, 32'h0000_0000));
        words.push_back(pack_word(OP_HEX32, 32'hFFFF_FFFF));
        words.push_back(pack_word(OP_HEX32, 32'h0123_4567));
        words.push_back(pack_word(OP_HEX32, 32'h89AB_CDEF));
        // dec16: zero, extremes, most negative, upper bits ignored
        words.push_back(pack_word(OP_DEC16, 32'h0000_0000));
        words.push_back(pack_word(OP_DEC16, 32'h0000_7FFF));
        words.push_back(pack_word(OP_DEC16, 32'h0000_8000));
        words.push_back(pack_word(OP_DEC16, 32'h0000_FFFF));
        words.push_back(pack_word(OP_DEC16, 32'hDEAD_0001));
        words.push_back(pack_word(OP_DEC16, 32'hFFFF_0000));
        words.push_back(pack_word(OP_DEC16, 32'h0000_3039));
        // dec32: zero, extremes, most negative, ten digits
        words.push_back(pack_word(OP_DEC32, 32'h0000_0000));
        words.push_back(pack_word(OP_DEC32, 32'h7FFF_FFFF));
        words.push_back(pack_word(OP_DEC32, 32'h8000_0000));
        words.push_back(pack_word(OP_DEC32, 32'hFFFF_FFFF));
        words.push_back(pack_word(OP_DEC32, 32'd1_000_000_000));
        words.push_back(pack_word(OP_DEC32, 32'h0000_0009));
        // meaningless opcodes must leave no trace in the output
        words.push_back(pack_word(OP_RSVD5, $urandom));
        words.push_back(pack_word(OP_RSVD6, $urandom));
        words.push_back(pack_word(OP_RSVD7, 32'hFFFF_FFFF));
        foreach (words[i]) begin
            send_word(words[i]);
        end
        directed_count = words.size();
    endtask

    // mix of full-range values, short magnitudes of both signs and values
    // next to the sign and wrap boundaries; a few meaningless opcodes
    function automatic t_in_word random_word();
        t_in_word    w;
        logic [31:0] v;
        logic [63:0] mask;
        if ($urandom_range(0, 19) == 0) begin
            w.opcode = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end else begin
            w.opcode = 3'($urandom_range(OP_HEX8, OP_DEC32));
        end
        mask = (64'd1 << $urandom_range(1, 32)) - 64'd1;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom & mask[31:0];
            2: v = -($urandom & mask[31:0]);
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_8000;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
                v = v + 32'($urandom_range(0, 2)) - 32'd1;
            end
        endcase
        // narrow modes must not look above their width
        if (w.opcode inside {OP_HEX8, OP_HEX16, OP_DEC16} && $urandom_range(0, 1) == 1) begin
            v[31:16] = 16'($urandom);
        end
        w.value = v;
        return w;
    endfunction

    initial begin : stimulus
        int unsigned sent_random;
        bit          paused_mid;
        t_in_word    w;
        sent_random = 0;
        paused_mid  = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_text();

        while (sent_random < ITEM_TARGET) begin
            w = random_word();
            send_word(w);
            if (w.opcode <= OP_DEC32) begin
                sent_random++;
            end
            if (!paused_mid && sent_random == ITEM_TARGET / 2) begin
                paused_mid = 1'b1;
                wait_for_text();
            end
        end

        // drain, then give a stray late character time to show up
        wait_for_text();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("spelled %0d values (%0d directed words), dropped %0d unknown opcodes,",
                 sb.values_spelled, directed_count, sb.ignored_words);
        $display("checked %0d characters over hex8/16/32 and signed dec16/32, %0d mismatches",
                 sb.chars_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
